FILE: design/srets_pkg.sv
package srets_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int SAMPLE_IN_W = 12;
    localparam int LEVEL_W     = 12;
    localparam int START_W     = 10;
    localparam int IDX_W       = 11;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;

    // Parameter defaults
    localparam int RING_DEPTH_DEF   = 2048;
    localparam int SAMPLE_WIDTH_DEF = 12;

    // Register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2048;
    localparam logic [START_W-1:0] START_RESET = 10'd64;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START_BACK = 2'd1;

    // Item kinds carried in tuser
    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PRIME,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

FILE: design/sample_ring_edge_trigger_search.sv
// Store item: taken when idle and the output slot is free; its result is valid in the next cycle.
// Search item: D = search_start_back is reduced modulo RING_DEPTH, the ring read is primed, then
// the scan makes n <= RING_DEPTH/2 compares with one ring read and one level compare per cycle.
// One item is worked on at a time; the next is taken once the result register is free or drains.
// Reset (rst_n low, asynchronous) clears the sequencer, newest position, fill count and counter;
// ring entries not yet written since reset read as zero through the fill count, no clearing pass.
module sample_ring_edge_trigger_search #(
    parameter int RING_DEPTH   = srets_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = srets_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: sample[11:0], overflow[12], rising_edge[13], zero[15:14]
    input  logic [srets_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: func[0]
    input  logic                              s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: trigger_index[10:0], found[11], newest_index[22:12], error_count[54:23], zero[55]
    output logic [srets_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srets_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srets_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = PTR_W - 1;
    localparam int RED_W  = (srets_pkg::START_W > PTR_W + 1) ? srets_pkg::START_W : PTR_W + 1;
    localparam int EXT_W  = (SAMPLE_WIDTH > srets_pkg::SAMPLE_IN_W) ?
                            SAMPLE_WIDTH : srets_pkg::SAMPLE_IN_W;
    localparam int OEXT_W = PTR_W + srets_pkg::IDX_W;

    localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_P    = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [RED_W-1:0] DEPTH_R    = RED_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] HALF_LAST  = CNT_W'(RING_DEPTH / 2 - 1);

    // Input field unpacking
    logic [srets_pkg::SAMPLE_IN_W-1:0] in_sample;
    logic                              in_overflow;
    logic                              in_rising;
    assign in_sample   = s_tdata[11:0];
    assign in_overflow = s_tdata[12];
    assign in_rising   = s_tdata[13];

    // Sequencer and datapath registers
    srets_pkg::state_t state_reg, state_next;

    logic [srets_pkg::LEVEL_W-1:0] level_reg;
    logic [srets_pkg::START_W-1:0] start_back_reg;
    logic [PTR_W-1:0]              newest_reg, newest_next;
    logic [PTR_W:0]                fill_reg, fill_next;
    logic [srets_pkg::COUNT_W-1:0] err_reg, err_next;

    logic [srets_pkg::START_W-1:0] dist_reg, dist_next;
    logic [PTR_W-1:0]              addr_reg, addr_next;
    logic [PTR_W-1:0]              x_reg, x_next;
    logic [SAMPLE_WIDTH-1:0]       a_reg, a_next;
    logic                          have_a_reg, have_a_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          rising_reg, rising_next;
    logic [PTR_W-1:0]              trig_reg, trig_next;
    logic                          found_reg, found_next;

    logic                          m_valid_reg, m_valid_next;
    logic [PTR_W-1:0]              out_trig_reg, out_trig_next;
    logic                          out_found_reg, out_found_next;
    logic [PTR_W-1:0]              out_newest_reg, out_newest_next;
    logic [srets_pkg::COUNT_W-1:0] out_err_reg, out_err_next;

    // Ring memory with a registered read port
    logic [SAMPLE_WIDTH-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_WIDTH-1:0] rdata_reg;
    logic [PTR_W-1:0]        cur_reg;
    logic                    ok_reg;

    logic                    slot_free;
    logic                    in_xfer;
    logic                    store_xfer;
    logic                    search_xfer;
    logic [PTR_W-1:0]        newest_inc;
    logic [PTR_W-1:0]        addr_prev;
    logic [EXT_W-1:0]        sample_ext;
    logic [SAMPLE_WIDTH-1:0] sample_st;
    logic [SAMPLE_WIDTH-1:0] data_eff;
    logic [RED_W-1:0]        dist_ext;
    logic                    dist_big;
    logic [PTR_W:0]          start_diff;
    logic [PTR_W:0]          start_wrap;
    logic [PTR_W-1:0]        start_pos;
    logic [EXT_W-1:0]        cmp_a;
    logic [EXT_W-1:0]        cmp_b;
    logic [EXT_W-1:0]        cmp_level;
    logic                    hit;
    logic                    scan_last;
    logic [OEXT_W-1:0]       trig_ext;
    logic [OEXT_W-1:0]       newest_ext;

    // Handshakes
    assign slot_free   = !m_valid_reg || m_tready;
    assign s_tready    = (state_reg == srets_pkg::ST_IDLE) && slot_free;
    assign in_xfer     = s_tvalid && s_tready;
    assign store_xfer  = in_xfer && (s_tuser == srets_pkg::FUNC_STORE);
    assign search_xfer = in_xfer && (s_tuser == srets_pkg::FUNC_SEARCH);
    assign cfg_ready   = 1'b1;

    // Ring position arithmetic
    assign newest_inc = (newest_reg == PTR_LAST) ? '0 : newest_reg + 1'b1;
    assign addr_prev  = (addr_reg == '0) ? PTR_LAST : addr_reg - 1'b1;

    // Sample resized to the ring width
    assign sample_ext = EXT_W'(in_sample);
    assign sample_st  = sample_ext[SAMPLE_WIDTH-1:0];

    // Entries beyond the fill count have not been written since reset and read as zero
    assign data_eff = ok_reg ? rdata_reg : '0;

    // Start distance reduction and start position
    assign dist_ext   = RED_W'(dist_reg);
    assign dist_big   = dist_ext >= DEPTH_R;
    assign start_diff = {1'b0, newest_reg} - {1'b0, dist_ext[PTR_W-1:0]};
    assign start_wrap = start_diff + DEPTH_P;
    assign start_pos  = start_diff[PTR_W] ? start_wrap[PTR_W-1:0] : start_diff[PTR_W-1:0];

    // Level crossing compare between the later sample a and the earlier sample b
    assign cmp_a     = EXT_W'(a_reg);
    assign cmp_b     = EXT_W'(data_eff);
    assign cmp_level = EXT_W'(level_reg);
    assign hit = rising_reg ? (cmp_a >= cmp_level && cmp_b < cmp_level)
                            : (cmp_a <= cmp_level && cmp_b > cmp_level);
    assign scan_last = (cnt_reg == HALF_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srets_pkg::ST_IDLE:
            begin
                if (search_xfer)
                    state_next = srets_pkg::ST_REDUCE;
            end
            srets_pkg::ST_REDUCE:
            begin
                if (!dist_big)
                    state_next = srets_pkg::ST_PRIME;
            end
            srets_pkg::ST_PRIME:
            begin
                state_next = srets_pkg::ST_SCAN;
            end
            srets_pkg::ST_SCAN:
            begin
                if (have_a_reg && (hit || scan_last))
                    state_next = srets_pkg::ST_RESULT;
            end
            srets_pkg::ST_RESULT:
            begin
                if (slot_free)
                    state_next = srets_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srets_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        newest_next     = newest_reg;
        fill_next       = fill_reg;
        err_next        = err_reg;
        dist_next       = dist_reg;
        addr_next       = addr_reg;
        x_next          = x_reg;
        a_next          = a_reg;
        have_a_next     = have_a_reg;
        cnt_next        = cnt_reg;
        rising_next     = rising_reg;
        trig_next       = trig_reg;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_trig_next   = out_trig_reg;
        out_found_next  = out_found_reg;
        out_newest_next = out_newest_reg;
        out_err_next    = out_err_reg;

        unique case (state_reg)
            srets_pkg::ST_IDLE:
            begin
                if (store_xfer)
                begin
                    newest_next = newest_inc;
                    if (fill_reg != DEPTH_P)
                        fill_next = fill_reg + 1'b1;
                    if (in_overflow)
                        err_next = err_reg + 1'b1;
                    m_valid_next    = 1'b1;
                    out_trig_next   = '0;
                    out_found_next  = 1'b0;
                    out_newest_next = newest_inc;
                    out_err_next    = in_overflow ? err_reg + 1'b1 : err_reg;
                end
                else if (search_xfer)
                begin
                    dist_next   = start_back_reg;
                    rising_next = in_rising;
                end
            end
            srets_pkg::ST_REDUCE:
            begin
                if (dist_big)
                begin
                    dist_next = srets_pkg::START_W'(dist_ext - DEPTH_R);
                end
                else
                begin
                    addr_next  = start_pos;
                    trig_next  = start_pos;
                    found_next = 1'b0;
                end
            end
            srets_pkg::ST_PRIME:
            begin
                addr_next   = addr_prev;
                have_a_next = 1'b0;
                cnt_next    = '0;
            end
            srets_pkg::ST_SCAN:
            begin
                if (!have_a_reg)
                begin
                    a_next      = data_eff;
                    x_next      = cur_reg;
                    addr_next   = addr_prev;
                    have_a_next = 1'b1;
                end
                else if (hit)
                begin
                    trig_next  = x_reg;
                    found_next = 1'b1;
                end
                else
                begin
                    a_next    = data_eff;
                    x_next    = cur_reg;
                    addr_next = addr_prev;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            srets_pkg::ST_RESULT:
            begin
                if (slot_free)
                begin
                    m_valid_next    = 1'b1;
                    out_trig_next   = trig_reg;
                    out_found_next  = found_reg;
                    out_newest_next = newest_reg;
                    out_err_next    = err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srets_pkg::ST_IDLE;
            level_reg      <= srets_pkg::LEVEL_RESET;
            start_back_reg <= srets_pkg::START_RESET;
            newest_reg     <= PTR_LAST;
            fill_reg       <= '0;
            err_reg        <= '0;
            have_a_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            newest_reg  <= newest_next;
            fill_reg    <= fill_next;
            err_reg     <= err_next;
            have_a_reg  <= have_a_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    srets_pkg::REG_TRIGGER_LEVEL:     level_reg <= cfg_data;
                    srets_pkg::REG_SEARCH_START_BACK: start_back_reg <= cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dist_reg       <= dist_next;
        addr_reg       <= addr_next;
        x_reg          <= x_next;
        a_reg          <= a_next;
        cnt_reg        <= cnt_next;
        rising_reg     <= rising_next;
        trig_reg       <= trig_next;
        found_reg      <= found_next;
        out_trig_reg   <= out_trig_next;
        out_found_reg  <= out_found_next;
        out_newest_reg <= out_newest_next;
        out_err_reg    <= out_err_next;
    end

    // Ring write on a store transfer, one registered read every cycle
    always_ff @(posedge clk)
    begin
        if (store_xfer)
            ring_mem[newest_inc] <= sample_st;
        rdata_reg <= ring_mem[addr_reg];
        cur_reg   <= addr_reg;
        ok_reg    <= {1'b0, addr_reg} < fill_reg;
    end

    // Result packing, indices cut to the output width
    assign trig_ext   = OEXT_W'(out_trig_reg);
    assign newest_ext = OEXT_W'(out_newest_reg);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {1'b0, out_err_reg, newest_ext[srets_pkg::IDX_W-1:0],
                         out_found_reg, trig_ext[srets_pkg::IDX_W-1:0]};

endmodule

FILE: design/srets_checker.sv
module srets_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [srets_pkg::M_TDATA_W-1:0]   m_tdata
);

    // A stalled result holds its value
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A store transfer yields its result on the next cycle with no trigger
    a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == srets_pkg::FUNC_STORE)
        |=> m_tvalid && (m_tdata[11:0] == 12'd0))
        else $error("store result missing or carries a trigger");

    // A new item is never taken while the pending result is blocked
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready)
        else $error("input taken while result blocked");

    // A search transfer produces no result on the next cycle
    a_search_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == srets_pkg::FUNC_SEARCH) && m_tready
        |=> !m_tvalid)
        else $error("search result too early");

endmodule

bind sample_ring_edge_trigger_search srets_checker u_srets_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RING         = srets_pkg::RING_DEPTH_DEF;
    localparam int HALF_RING    = RING / 2;
    localparam int PHASE_ITEMS  = 272;
    localparam int SETTLE       = 8;
    localparam int LIMIT_CYCLES = 8000000;
    localparam int MAX_PRINTED  = 40;

    // One result transfer as seen on m_tdata
    typedef struct {
        logic [srets_pkg::IDX_W-1:0]   trigger_index;
        logic                          found;
        logic [srets_pkg::IDX_W-1:0]   newest_index;
        logic [srets_pkg::COUNT_W-1:0] error_count;
    } trigger_report_t;

    // Mirror of the capture ring and the reports it should produce
    class trigger_scoreboard;
        bit [srets_pkg::SAMPLE_IN_W-1:0] ring [RING];
        bit [srets_pkg::IDX_W-1:0]       newest;
        bit [srets_pkg::COUNT_W-1:0]     overflow_total;
        bit [srets_pkg::LEVEL_W-1:0]     level;
        bit [srets_pkg::START_W-1:0]     start_back;
        trigger_report_t                 predicted_reports[$];
        int                              failures;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            newest         = srets_pkg::IDX_W'(RING - 1);
            overflow_total = '0;
            level          = srets_pkg::LEVEL_RESET;
            start_back     = srets_pkg::START_RESET;
            failures       = 0;
        endfunction

        function void apply_config(logic [srets_pkg::CFG_IDX_W-1:0] idx,
                                   logic [srets_pkg::CFG_DATA_W-1:0] data);
            if (idx == srets_pkg::REG_TRIGGER_LEVEL)
                level = data[srets_pkg::LEVEL_W-1:0];
            else if (idx == srets_pkg::REG_SEARCH_START_BACK)
                start_back = data[srets_pkg::START_W-1:0];
        endfunction

        // Walk backward over half the ring looking for the first level crossing
        function void locate_edge(bit rising, output bit [srets_pkg::IDX_W-1:0] where,
                                  output bit hit);
            bit [srets_pkg::IDX_W-1:0] x;
            bit [srets_pkg::IDX_W-1:0] prev;
            bit [srets_pkg::SAMPLE_IN_W-1:0] a;
            bit [srets_pkg::SAMPLE_IN_W-1:0] b;
            x     = newest - srets_pkg::IDX_W'(start_back);
            where = x;
            hit   = 1'b0;
            for (int i = 0; i < HALF_RING; i++)
            begin
                prev = x - 1'b1;
                a    = ring[x];
                b    = ring[prev];
                if (rising ? (a >= level && b < level) : (a <= level && b > level))
                begin
                    where = x;
                    hit   = 1'b1;
                    break;
                end
                x = prev;
            end
        endfunction

        // Update the mirror for one accepted input transfer and queue its report
        function void note_input(logic [srets_pkg::S_TDATA_W-1:0] tdata, logic tuser);
            trigger_report_t rep;
            bit [srets_pkg::IDX_W-1:0] where;
            bit hit;
            rep.trigger_index = '0;
            rep.found         = 1'b0;
            if (tuser == srets_pkg::FUNC_STORE)
            begin
                if (tdata[srets_pkg::SAMPLE_IN_W])
                    overflow_total++;
                newest       = newest + 1'b1;
                ring[newest] = tdata[srets_pkg::SAMPLE_IN_W-1:0];
            end
            else
            begin
                locate_edge(tdata[srets_pkg::SAMPLE_IN_W+1], where, hit);
                rep.trigger_index = where;
                rep.found         = hit;
            end
            rep.newest_index = newest;
            rep.error_count  = overflow_total;
            predicted_reports.push_back(rep);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            failures++;
            if (failures <= MAX_PRINTED)
                $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        endtask

        // Compare one result transfer with the oldest queued report
        task check_result(logic [srets_pkg::M_TDATA_W-1:0] tdata);
            localparam int IW = srets_pkg::IDX_W;
            localparam int CW = srets_pkg::COUNT_W;
            trigger_report_t want;
            if (predicted_reports.size() == 0)
            begin
                report("unexpected result", tdata, 0);
                return;
            end
            want = predicted_reports.pop_front();
            if (tdata[IW-1:0] !== want.trigger_index)
                report("trigger_index", tdata[IW-1:0], want.trigger_index);
            if (tdata[IW] !== want.found)
                report("found", tdata[IW], want.found);
            if (tdata[2*IW:IW+1] !== want.newest_index)
                report("newest_index", tdata[2*IW:IW+1], want.newest_index);
            if (tdata[2*IW+CW:2*IW+1] !== want.error_count)
                report("error_count", tdata[2*IW+CW:2*IW+1], want.error_count);
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [srets_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                              s_tuser = srets_pkg::FUNC_STORE;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [srets_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [srets_pkg::CFG_IDX_W-1:0]   cfg_index = srets_pkg::REG_TRIGGER_LEVEL;
    logic [srets_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    trigger_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;

    sample_ring_edge_trigger_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe every transfer on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.apply_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tuser);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one item, after a random gap, and hold it until the transfer
    task automatic send_item(input logic func, input logic [srets_pkg::SAMPLE_IN_W-1:0] smp,
                             input logic ovf, input logic rising);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, rising, ovf, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop sending and wait until every queued report has come back
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.predicted_reports.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write both registers back to back; the block is idle here
    task automatic set_config(input logic [srets_pkg::LEVEL_W-1:0] level,
                              input logic [srets_pkg::START_W-1:0] back);
        cfg_valid <= 1'b1;
        cfg_index <= srets_pkg::REG_TRIGGER_LEVEL;
        cfg_data  <= level;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= srets_pkg::REG_SEARCH_START_BACK;
        cfg_data  <= srets_pkg::CFG_DATA_W'(back);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A waveform that wanders across the trigger level, followed by a search
    task automatic edge_burst;
        int n;
        logic hi;
        logic [srets_pkg::SAMPLE_IN_W-1:0] v;
        n  = $urandom_range(40, 4);
        hi = 1'($urandom_range(1));
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                hi = ~hi;
            if ($urandom_range(5) == 0)
                v = sb.level;
            else if (hi)
                v = srets_pkg::SAMPLE_IN_W'($urandom_range(4095, sb.level));
            else
                v = srets_pkg::SAMPLE_IN_W'($urandom_range(sb.level, 0));
            send_item(srets_pkg::FUNC_STORE, v, $urandom_range(9) == 0,
                      1'($urandom_range(1)));
        end
        send_item(srets_pkg::FUNC_SEARCH, srets_pkg::SAMPLE_IN_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Unstructured items with random content
    task automatic noise_burst;
        int n;
        n = $urandom_range(10, 1);
        repeat (n)
            send_item(($urandom_range(4) == 0) ? srets_pkg::FUNC_SEARCH : srets_pkg::FUNC_STORE,
                      srets_pkg::SAMPLE_IN_W'($urandom),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [srets_pkg::LEVEL_W-1:0] level,
                             input logic [srets_pkg::START_W-1:0] back);
        int target;
        int pick;
        drain_results(SETTLE);
        set_config(level, back);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                edge_burst();
            else if (pick < 85)
                noise_burst();
            else
                send_item(srets_pkg::FUNC_SEARCH, srets_pkg::SAMPLE_IN_W'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Searches over the empty ring find nothing; fields unused by a search are set
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'hFFF, 1'b1, 1'b1);
        // Stores at the sample extremes and around the level; rising_edge is ignored here
        send_item(srets_pkg::FUNC_STORE, 12'hFFF, 1'b1, 1'b1);
        send_item(srets_pkg::FUNC_STORE, 12'h000, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_STORE, 12'd2048, 1'b1, 1'b0);
        send_item(srets_pkg::FUNC_STORE, 12'd2047, 1'b0, 1'b1);
        send_item(srets_pkg::FUNC_STORE, 12'd2049, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'hAAA, 1'b0, 1'b1);

        // Search from the newest sample in both directions, including an exact hit on the level
        drain_results(SETTLE);
        set_config(12'd2048, 10'd0);
        send_item(srets_pkg::FUNC_SEARCH, 12'h555, 1'b1, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b1);
        send_item(srets_pkg::FUNC_STORE, 12'd2048, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b1);

        // Start point at index zero, so the first compare wraps to the top of the ring
        drain_results(SETTLE);
        set_config(12'd2048, 10'd5);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b1);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b0);

        // A start distance beyond the newest position wraps below index zero
        drain_results(SETTLE);
        set_config(12'd1, 10'd1023);
        send_item(srets_pkg::FUNC_STORE, 12'h000, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b0, 1'b0);
        send_item(srets_pkg::FUNC_SEARCH, 12'h000, 1'b1, 1'b1);

        // Random phases with different idling and register settings
        run_phase(0, 0, 12'd0, 10'd1023);
        run_phase(71, 0, 12'd4095, 10'd0);
        run_phase(0, 71, srets_pkg::LEVEL_W'($urandom_range(4095)),
                  srets_pkg::START_W'($urandom_range(1023)));
        run_phase(26, 26, srets_pkg::LEVEL_W'($urandom_range(3072, 1024)),
                  srets_pkg::START_W'($urandom_range(127)));

        drain_results(HALF_RING + 16);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
